// ===== rtl/rnsc_pkg.sv =====
// Package with widths, register map, constants and payload types of the rotation address generator.
package rnsc_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 14;

  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int TRIG_W  = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = TRIG_W + DIFF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int POS_W   = SUM_W - FRAC_BITS;
  localparam int INDEX_W = 24;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [2:0] REG_SINE       = 3'd0;
  localparam logic [2:0] REG_COSINE     = 3'd1;
  localparam logic [2:0] REG_SRC_ROWS   = 3'd2;
  localparam logic [2:0] REG_SRC_COLS   = 3'd3;
  localparam logic [2:0] REG_CENTER_ROW = 3'd4;
  localparam logic [2:0] REG_CENTER_COL = 3'd5;

  localparam logic signed [TRIG_W-1:0] SINE_RESET   = 16'sd0;
  localparam logic signed [TRIG_W-1:0] COSINE_RESET = 16'sd16384;
  localparam logic [DIM_W-1:0]         DIM_RESET    = 13'd1;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
  } pix_t;

  typedef struct packed {
    logic               in_range;
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] src_col;
    logic [INDEX_W-1:0] src_pixel_index;
  } res_t;

endpackage

// ===== rtl/rotate_nearest_source_coord.sv =====
// Top level of the nearest-neighbour rotation source address generator.
// Pipeline: five register stages; the first loads at the edge that accepts an input transaction,
// and the result then passes through the remaining stages to res.
// Throughput: one transaction per cycle unless res stalls; each of the five register stages moves
// whenever the stage after it is empty or moving, so a stall on res only holds data.
// Reset: rst is synchronous and active high; it empties the pipeline and loads the
// register reset values (sine 0, cosine 1.0, source 1x1, output centre 0,0).
module rotate_nearest_source_coord
  import rnsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB-style configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // Output pixel coordinates.
  input  logic              pix_valid,
  output logic              pix_ready,
  input  pix_t              pix,
  // Source pixel results.
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  // Configuration registers.
  logic signed [TRIG_W-1:0] sine_q14;
  logic signed [TRIG_W-1:0] cosine_q14;
  logic [DIM_W-1:0]         src_rows;
  logic [DIM_W-1:0]         src_cols;
  logic [COORD_W-1:0]       out_center_row;
  logic [COORD_W-1:0]       out_center_col;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_q14       <= SINE_RESET;
      cosine_q14     <= COSINE_RESET;
      src_rows       <= DIM_RESET;
      src_cols       <= DIM_RESET;
      out_center_row <= '0;
      out_center_col <= '0;
    end else if (cfg_write) begin
      case (paddr[ADDR_W-1:2])
        REG_SINE:       sine_q14       <= pwdata[TRIG_W-1:0];
        REG_COSINE:     cosine_q14     <= pwdata[TRIG_W-1:0];
        REG_SRC_ROWS:   src_rows       <= pwdata[DIM_W-1:0];
        REG_SRC_COLS:   src_cols       <= pwdata[DIM_W-1:0];
        REG_CENTER_ROW: out_center_row <= pwdata[COORD_W-1:0];
        REG_CENTER_COL: out_center_col <= pwdata[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Reads return the register value; the signed registers come back sign extended.
  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_SINE:       prdata = {{(DATA_W-TRIG_W){sine_q14[TRIG_W-1]}}, sine_q14};
      REG_COSINE:     prdata = {{(DATA_W-TRIG_W){cosine_q14[TRIG_W-1]}}, cosine_q14};
      REG_SRC_ROWS:   prdata = {{(DATA_W-DIM_W){1'b0}}, src_rows};
      REG_SRC_COLS:   prdata = {{(DATA_W-DIM_W){1'b0}}, src_cols};
      REG_CENTER_ROW: prdata = {{(DATA_W-COORD_W){1'b0}}, out_center_row};
      REG_CENTER_COL: prdata = {{(DATA_W-COORD_W){1'b0}}, out_center_col};
      default:        prdata = '0;
    endcase
  end

  // Source sizes above the maximum saturate; the centre is half the saturated size.
  logic [DIM_W-1:0]   rows_sat;
  logic [DIM_W-1:0]   cols_sat;
  logic [COORD_W-1:0] row_center;
  logic [COORD_W-1:0] col_center;

  assign rows_sat   = (src_rows > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : src_rows;
  assign cols_sat   = (src_cols > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : src_cols;
  assign row_center = rows_sat[DIM_W-1:1];
  assign col_center = cols_sat[DIM_W-1:1];

  // Stage enables. A stage loads when it is empty or its content moves on.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  assign en5       = !v5 || res_ready;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign pix_ready = en1;
  assign res_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= pix_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Stage 1: offsets of the output pixel from the output centre.
  logic signed [DIFF_W-1:0] d_row;
  logic signed [DIFF_W-1:0] d_col;

  always_ff @(posedge clk) begin
    if (en1) begin
      d_row <= $signed({1'b0, pix.out_row}) - $signed({1'b0, out_center_row});
      d_col <= $signed({1'b0, pix.out_col}) - $signed({1'b0, out_center_col});
    end
  end

  // Stage 2: the four rotation products, each exact in PROD_W bits.
  logic signed [PROD_W-1:0] p_cos_row;
  logic signed [PROD_W-1:0] p_sin_col;
  logic signed [PROD_W-1:0] p_sin_row;
  logic signed [PROD_W-1:0] p_cos_col;

  always_ff @(posedge clk) begin
    if (en2) begin
      p_cos_row <= PROD_W'(cosine_q14) * PROD_W'(d_row);
      p_sin_col <= PROD_W'(sine_q14) * PROD_W'(d_col);
      p_sin_row <= PROD_W'(sine_q14) * PROD_W'(d_row);
      p_cos_col <= PROD_W'(cosine_q14) * PROD_W'(d_col);
    end
  end

  // Stage 3: fixed-point source position, source centre included.
  logic signed [SUM_W-1:0] row_base;
  logic signed [SUM_W-1:0] col_base;
  logic signed [SUM_W-1:0] row_sum;
  logic signed [SUM_W-1:0] col_sum;

  assign row_base = $signed({{(SUM_W-COORD_W-FRAC_BITS){1'b0}}, row_center,
                             {FRAC_BITS{1'b0}}});
  assign col_base = $signed({{(SUM_W-COORD_W-FRAC_BITS){1'b0}}, col_center,
                             {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (en3) begin
      row_sum <= row_base + SUM_W'(p_cos_row) - SUM_W'(p_sin_col);
      col_sum <= col_base + SUM_W'(p_sin_row) + SUM_W'(p_cos_col);
    end
  end

  // Stage 4: truncate toward zero and test against the source bounds. Adding
  // one less than the scale to a negative sum before the arithmetic shift turns
  // the floor of the shift into truncation toward zero.
  localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << FRAC_BITS) - 1);

  logic signed [SUM_W-1:0] row_adj;
  logic signed [SUM_W-1:0] col_adj;
  logic signed [POS_W-1:0] row_pos;
  logic signed [POS_W-1:0] col_pos;
  logic                    row_ok;
  logic                    col_ok;
  logic                    src_in;
  logic [COORD_W-1:0]      s_row;
  logic [COORD_W-1:0]      s_col;

  always_comb begin
    row_adj = row_sum + (row_sum[SUM_W-1] ? TRUNC_BIAS : '0);
    col_adj = col_sum + (col_sum[SUM_W-1] ? TRUNC_BIAS : '0);
    row_pos = POS_W'(row_adj >>> FRAC_BITS);
    col_pos = POS_W'(col_adj >>> FRAC_BITS);
    row_ok  = !row_pos[POS_W-1] &&
              (row_pos[POS_W-2:0] < {{(POS_W-1-DIM_W){1'b0}}, rows_sat});
    col_ok  = !col_pos[POS_W-1] &&
              (col_pos[POS_W-2:0] < {{(POS_W-1-DIM_W){1'b0}}, cols_sat});
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      src_in <= row_ok && col_ok;
      s_row  <= (row_ok && col_ok) ? row_pos[COORD_W-1:0] : '0;
      s_col  <= (row_ok && col_ok) ? col_pos[COORD_W-1:0] : '0;
    end
  end

  // Stage 5: linear index. Out of range both coordinates are zero, so is the index.
  logic [COORD_W+DIM_W-1:0] index_full;

  assign index_full = (COORD_W+DIM_W)'(s_row) * (COORD_W+DIM_W)'(cols_sat)
                      + (COORD_W+DIM_W)'(s_col);

  always_ff @(posedge clk) begin
    if (en5) begin
      res.in_range        <= src_in;
      res.src_row         <= s_row;
      res.src_col         <= s_col;
      res.src_pixel_index <= index_full[INDEX_W-1:0];
    end
  end

endmodule

// ===== rtl/rnsc_checker.sv =====
// Port-level checker for the rotation address generator, bound to the top level.
module rnsc_checker
  import rnsc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic pready,
  input logic pix_ready,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // A stalled result transaction keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // An out-of-range result carries zero coordinates and index.
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.in_range |->
      res.src_row == '0 && res.src_col == '0 && res.src_pixel_index == '0)
    else $error("out-of-range result with nonzero address");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // With the output free, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> pix_ready)
    else $error("input stalled while output was ready");

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk)
    pready)
    else $error("pready low");

endmodule

bind rotate_nearest_source_coord rnsc_checker u_rnsc_checker (.*);

// ===== test/source_coord_checker.sv =====
// Checker that predicts and compares the source addresses of the rotation address generator.
`timescale 1ns / 100ps

module source_coord_checker
  import rnsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  input  logic              pix_valid,
  input  logic              pix_ready,
  input  pix_t              pix,
  input  logic              res_valid,
  input  logic              res_ready,
  input  res_t              res,
  output int                errors,
  output int                outstanding
);

  // Shadow copy of the configuration registers.
  logic signed [TRIG_W-1:0] sine_cfg;
  logic signed [TRIG_W-1:0] cosine_cfg;
  logic [DIM_W-1:0]         rows_cfg;
  logic [DIM_W-1:0]         cols_cfg;
  logic [COORD_W-1:0]       center_row_cfg;
  logic [COORD_W-1:0]       center_col_cfg;

  // Source addresses still owed by the block, oldest first.
  res_t pending_src[$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t checker: %s got %0d want %0d", $realtime, what, got, want);
    errors = errors + 1;
  endtask

  // Maps one output pixel back into the source image.
  function automatic res_t map_to_source(input pix_t p);
    longint rows;
    longint cols;
    longint unit;
    longint di;
    longint dj;
    longint row_sum;
    longint col_sum;
    longint sr;
    longint sc;
    longint idx;
    res_t   r;
    r    = '0;
    rows = (rows_cfg > MAX_DIM) ? MAX_DIM : longint'(rows_cfg);
    cols = (cols_cfg > MAX_DIM) ? MAX_DIM : longint'(cols_cfg);
    unit = longint'(1) << FRAC_BITS;
    di   = longint'(p.out_row) - longint'(center_row_cfg);
    dj   = longint'(p.out_col) - longint'(center_col_cfg);
    row_sum = (rows / 2) * unit + longint'(cosine_cfg) * di - longint'(sine_cfg) * dj;
    col_sum = (cols / 2) * unit + longint'(sine_cfg) * di + longint'(cosine_cfg) * dj;
    // Signed division truncates toward zero, as the float-to-int conversion does.
    sr = row_sum / unit;
    sc = col_sum / unit;
    if (sr >= 0 && sr < rows && sc >= 0 && sc < cols) begin
      idx               = sr * cols + sc;
      r.in_range        = 1'b1;
      r.src_row         = sr[COORD_W-1:0];
      r.src_col         = sc[COORD_W-1:0];
      r.src_pixel_index = idx[INDEX_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      sine_cfg       <= SINE_RESET;
      cosine_cfg     <= COSINE_RESET;
      rows_cfg       <= DIM_RESET;
      cols_cfg       <= DIM_RESET;
      center_row_cfg <= '0;
      center_col_cfg <= '0;
      pending_src.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SINE:       sine_cfg       <= pwdata[TRIG_W-1:0];
          REG_COSINE:     cosine_cfg     <= pwdata[TRIG_W-1:0];
          REG_SRC_ROWS:   rows_cfg       <= pwdata[DIM_W-1:0];
          REG_SRC_COLS:   cols_cfg       <= pwdata[DIM_W-1:0];
          REG_CENTER_ROW: center_row_cfg <= pwdata[COORD_W-1:0];
          REG_CENTER_COL: center_col_cfg <= pwdata[COORD_W-1:0];
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (pending_src.size() == 0) begin
          report_mismatch("result with nothing pending", longint'(res), 0);
        end else begin
          want = pending_src.pop_front();
          if (res.in_range !== want.in_range)
            report_mismatch("in_range", res.in_range, want.in_range);
          if (res.src_row !== want.src_row)
            report_mismatch("src_row", res.src_row, want.src_row);
          if (res.src_col !== want.src_col)
            report_mismatch("src_col", res.src_col, want.src_col);
          if (res.src_pixel_index !== want.src_pixel_index)
            report_mismatch("src_pixel_index", res.src_pixel_index, want.src_pixel_index);
        end
      end
      if (pix_valid && pix_ready)
        pending_src.push_back(map_to_source(pix));
    end
    outstanding <= pending_src.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top that drives the rotation address generator and gives the verdict.
`timescale 1ns / 100ps

module tb_top
  import rnsc_pkg::*;
();

  // Register slots past the end of the map; writes there must be ignored.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Generous bound: several times the slowest legal run.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 53;
  localparam int DRAIN_CYCLES  = 10;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              pix_valid;
  logic              pix_ready;
  pix_t              pix;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  int errors;
  int outstanding;

  // When clear, the pixel sender runs back to back for the whole phase.
  bit gaps_on;

  rotate_nearest_source_coord dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  source_coord_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix         (pix),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap before the next pixel transaction: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One register write: setup cycle, then the access cycle that completes when
  // pready is seen high at a rising edge. Entered and left at a falling edge.
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Loads the full geometry. The bits above each register's width carry random
  // junk, which the block has to drop.
  task automatic set_geometry(input logic [TRIG_W-1:0] sine, input logic [TRIG_W-1:0] cosine,
                              input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                              input logic [COORD_W-1:0] crow, input logic [COORD_W-1:0] ccol);
    logic [DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(REG_SINE,       {junk[DATA_W-1:TRIG_W], sine});
    junk = $urandom;
    write_reg(REG_COSINE,     {junk[DATA_W-1:TRIG_W], cosine});
    junk = $urandom;
    write_reg(REG_SRC_ROWS,   {junk[DATA_W-1:DIM_W], rows});
    junk = $urandom;
    write_reg(REG_SRC_COLS,   {junk[DATA_W-1:DIM_W], cols});
    junk = $urandom;
    write_reg(REG_CENTER_ROW, {junk[DATA_W-1:COORD_W], crow});
    junk = $urandom;
    write_reg(REG_CENTER_COL, {junk[DATA_W-1:COORD_W], ccol});
  endtask

  // Offers one pixel and returns at the falling edge after its transaction.
  // Valid is lowered only when a gap follows, so a back-to-back pixel keeps
  // valid high and just swaps the payload after acceptance.
  task automatic send_pixel(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      pix_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid   = 1'b1;
    pix.out_row = r;
    pix.out_col = c;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering pixels and waits until every transaction has produced its
  // result, so that the next geometry is written while the block is idle.
  task automatic drain();
    pix_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Picks a random geometry. Most angles lie on the unit circle, some use raw
  // 16-bit values that go past +-1.0. Sizes are mostly small, a few are large,
  // zero or oversized. The output centre follows the rotated extent, so most
  // output pixels land inside the source image.
  task automatic random_phase();
    int               s;
    int               c;
    int               rows;
    int               cols;
    int               ext_r;
    int               ext_c;
    int               crow;
    int               ccol;
    int               span_r;
    int               span_c;
    int               roll;
    logic [TRIG_W-1:0] s16;
    logic [TRIG_W-1:0] c16;
    if ($urandom_range(0, 99) < 80) begin
      s = int'($urandom_range(0, 32768)) - 16384;
      c = $rtoi($sqrt(268435456.0 - real'(s * s)));
      if ($urandom_range(0, 1))
        c = -c;
    end else begin
      s = int'($urandom_range(0, 65535)) - 32768;
      c = int'($urandom_range(0, 65535)) - 32768;
    end
    s16 = s[TRIG_W-1:0];
    c16 = c[TRIG_W-1:0];
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      rows = $urandom_range(1, 200);
      cols = $urandom_range(1, 200);
    end else if (roll < 95) begin
      rows = $urandom_range(201, 4096);
      cols = $urandom_range(1, 4096);
    end else begin
      rows = $urandom_range(0, 1) ? 0 : $urandom_range(4097, 8191);
      cols = $urandom_range(0, 8191);
    end
    ext_r = ((s < 0 ? -s : s) * (cols > MAX_DIM ? MAX_DIM : cols)
             + (c < 0 ? -c : c) * (rows > MAX_DIM ? MAX_DIM : rows)) >> FRAC_BITS;
    ext_c = ((s < 0 ? -s : s) * (rows > MAX_DIM ? MAX_DIM : rows)
             + (c < 0 ? -c : c) * (cols > MAX_DIM ? MAX_DIM : cols)) >> FRAC_BITS;
    crow = (ext_r / 2 > 4095) ? 4095 : ext_r / 2;
    ccol = (ext_c / 2 > 4095) ? 4095 : ext_c / 2;
    if ($urandom_range(0, 99) < 15) begin
      crow = $urandom_range(0, 4095);
      ccol = $urandom_range(0, 4095);
    end
    span_r = (2 * crow + 1 > 4095) ? 4095 : 2 * crow + 1;
    span_c = (2 * ccol + 1 > 4095) ? 4095 : 2 * ccol + 1;
    set_geometry(s16, c16, rows[DIM_W-1:0], cols[DIM_W-1:0],
                 crow[COORD_W-1:0], ccol[COORD_W-1:0]);
    if ($urandom_range(0, 99) < 20)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    gaps_on = ($urandom_range(0, 99) < 80);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if ($urandom_range(0, 99) < 75)
        send_pixel(COORD_W'($urandom_range(0, span_r)), COORD_W'($urandom_range(0, span_c)));
      else
        send_pixel(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)));
    end
    drain();
  endtask

  // Result side: ready-stalls of random length, mostly short with a few long
  // ones, and stretches in which ready stays high throughout.
  initial begin : ready_gen
    int hold;
    int roll;
    bit stalling;
    res_ready = 1'b0;
    hold      = 0;
    stalling  = 1'b1;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          stalling = 1'b0;
          hold     = $urandom_range(10, 60);
        end else if (roll < 60) begin
          stalling = 1'b0;
          hold     = $urandom_range(1, 4);
        end else if (roll < 92) begin
          stalling = 1'b1;
          hold     = $urandom_range(1, 3);
        end else begin
          stalling = 1'b1;
          hold     = $urandom_range(10, 40);
        end
      end
      res_ready = !stalling;
      hold      = hold - 1;
    end
  end

  // Watchdog: a run that has not finished by the limit counts as a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles = cycles + 1;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    // Every input is known from time zero, when reset is raised.
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    pix_valid = 1'b0;
    pix       = '0;
    gaps_on   = 1'b1;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Reset geometry: a 1x1 source with both centres at the origin. Only the
    // origin maps inside; the far corner does not.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();

    // Identity on a 64x48 source with matching centres: the corners of the
    // source come back unchanged, one step past an edge falls outside, and the
    // extremes of both fields are far outside.
    set_geometry(16'sd0, 16'sd16384, 13'd64, 13'd48, 12'd32, 12'd24);
    send_pixel(12'd32, 12'd24);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd63, 12'd47);
    send_pixel(12'd64, 12'd24);
    send_pixel(12'd32, 12'd48);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    drain();

    // Quarter turn on the largest legal source, centred on both sides.
    set_geometry(16'sd16384, 16'sd0, 13'd4096, 13'd4096, 12'd2048, 12'd2048);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    drain();

    // Sine and cosine at the ends of their 16-bit range, well beyond +-1.0,
    // with both source sizes past the maximum so that they saturate.
    set_geometry(16'sh8000, 16'sh7fff, 13'd8191, 13'd4097, 12'd4095, 12'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd4000, 12'd5);
    send_pixel(12'd0, 12'd4095);
    drain();

    // Zero source height: nothing can be inside. Writes to the slots past the
    // register map must leave the geometry untouched.
    set_geometry(16'sd0, 16'sd16384, 13'd0, 13'd10, 12'd0, 12'd5);
    write_reg(REG_SPARE_LO, 32'hffff_ffff);
    write_reg(REG_SPARE_HI, 32'h0000_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd5, 12'd5);
    drain();

    // A 2x2 source at thirty degrees about the output origin: the fractional sums
    // must truncate to source coordinates, and one of the pixels lands outside.
    set_geometry(16'sd8192, 16'sd14189, 13'd2, 13'd2, 12'd0, 12'd0);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd1, 12'd1);
    drain();

    // Random geometries, each followed by a batch of random pixels.
    for (int p = 0; p < RANDOM_PHASES; p++)
      random_phase();

    // Everything has come back; give stray results time to show up.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
